@@ rtl/bca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants for the bitmap chunk allocator
// Sizes, request/status codes, sequencer states and the shared ALU interface.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int CHUNK_COUNT = 64;
  localparam int IDX_W       = $clog2(CHUNK_COUNT);
  localparam int STEP_W      = $clog2(IDX_W + 1);
  localparam int CS_W        = 16;
  localparam int REQ_W       = 32;
  localparam int OFF_W       = 22;
  localparam int MAP_W       = 64;
  localparam int DVS_W       = CS_W + IDX_W;
  localparam int ALU_W       = 32;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic            REG_IDX_CHUNK_SIZE = 1'b0;
  localparam logic [CS_W-1:0] CHUNK_SIZE_RESET   = 16'd1;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_RESIZE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_OUTSIDE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;  // on subtract: a >= b
  } alu_rsp_t;

endpackage

@@ rtl/bitmap_chunk_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator: 64-chunk page allocator with usage bitmap
// Requests come in on a valid/ready channel (func, request_size, offset) and
// each one produces exactly one result on a valid/ready output channel
// (status, result_offset, chunk_index, page_full, usage_map).
// Allocate takes the lowest free chunk; free maps an offset to its chunk by
// division with the chunk size; resize checks the new size against it.
// The chunk size is set through the APB port (register 0, reset value 1) and
// may only be changed while no request is in flight.
// Allocate runs a compare, 6 shift-add multiply steps and the result, free a
// range check, 6 restoring division steps and the result, resize a compare
// and the result, an unused kind only the result, all on the shared adder.
// One request is worked on at a time; in_ready_o is high only while idle.
// A result sits in an output register; the next request is taken while it
// waits, and finishing that request waits until the receiver takes it.
// Reset empties the bitmap (every chunk free) and clears the output valid flag.
// ----------------------------------------------------------------------------
module bitmap_chunk_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bca_pkg::APB_AW-1:0]   paddr,
  input  logic [bca_pkg::APB_DW-1:0]   pwdata,
  output logic [bca_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [bca_pkg::REQ_W-1:0]    request_size_i,
  input  logic [bca_pkg::OFF_W-1:0]    offset_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [bca_pkg::OFF_W-1:0]    result_offset_o,
  output logic [bca_pkg::IDX_W-1:0]    chunk_index_o,
  output logic                         page_full_o,
  output logic [bca_pkg::MAP_W-1:0]    usage_map_o
);

  bca_pkg::state_e state_q, state_d;

  logic [bca_pkg::CS_W-1:0]        cs_q;
  logic [bca_pkg::CHUNK_COUNT-1:0] used_q, used_d;

  bca_pkg::func_e                  func_q;
  bca_pkg::status_e                stat_q;
  logic [bca_pkg::REQ_W-1:0]       req_q;
  logic [bca_pkg::OFF_W-1:0]       off_q;
  logic [bca_pkg::OFF_W-1:0]       rem_q;
  logic [bca_pkg::DVS_W-1:0]       dvs_q;
  logic [bca_pkg::IDX_W-1:0]       quo_q;   // quotient, or multiplier shift reg
  logic [bca_pkg::STEP_W-1:0]      step_q;
  logic [bca_pkg::OFF_W-1:0]       acc_q;
  logic [bca_pkg::IDX_W-1:0]       idx_q;
  logic [bca_pkg::OFF_W-1:0]       res_off_q;

  logic                            out_valid_q;
  logic [1:0]                      out_status_q;
  logic [bca_pkg::OFF_W-1:0]       out_offset_q;
  logic [bca_pkg::IDX_W-1:0]       out_index_q;
  logic                            out_full_q;
  logic [bca_pkg::MAP_W-1:0]       out_map_q;

  bca_pkg::alu_req_t               alu_req;
  bca_pkg::alu_rsp_t               alu_rsp;

  logic                            take;
  logic                            step_last;
  logic                            range_step;
  logic                            out_free;
  logic                            page_is_full;
  logic                            cfg_write;
  logic [bca_pkg::CHUNK_COUNT-1:0] low_onehot;
  logic [bca_pkg::CHUNK_COUNT-1:0] chunk_mask;
  logic [bca_pkg::IDX_W-1:0]       low_idx;
  logic [bca_pkg::IDX_W-1:0]       q_new;

  bca_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // --------------------------------------------------------------------------
  // APB register
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == bca_pkg::REG_IDX_CHUNK_SIZE) ?
                     bca_pkg::APB_DW'(cs_q) : '0;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign take         = alu_rsp.carry;
  assign step_last    = (step_q == '0);
  assign range_step   = (step_q == bca_pkg::STEP_W'(bca_pkg::IDX_W));
  assign out_free     = !out_valid_q || out_ready_i;
  assign page_is_full = &used_q;
  assign q_new        = bca_pkg::IDX_W'({quo_q, take});
  assign chunk_mask   = bca_pkg::CHUNK_COUNT'(1) << idx_q;

  // lowest clear bit isolated by a carry through the used bits
  assign low_onehot = ~used_q & (used_q + bca_pkg::CHUNK_COUNT'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < bca_pkg::CHUNK_COUNT; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | bca_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (stat_q == bca_pkg::STAT_OK) begin
      unique case (func_q)
        bca_pkg::FUNC_ALLOC: used_d = used_q | chunk_mask;
        bca_pkg::FUNC_FREE:  used_d = used_q & ~chunk_mask;
        default:             used_d = used_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (bca_pkg::func_e'(func_i))
            bca_pkg::FUNC_ALLOC:  state_d = bca_pkg::S_CHECK;
            bca_pkg::FUNC_RESIZE: state_d = bca_pkg::S_CHECK;
            bca_pkg::FUNC_FREE:   state_d = bca_pkg::S_DIV;
            default:              state_d = bca_pkg::S_DONE;
          endcase
        end
      end
      bca_pkg::S_CHECK: begin
        if (func_q == bca_pkg::FUNC_ALLOC && take && !page_is_full) begin
          state_d = bca_pkg::S_MUL;
        end else begin
          state_d = bca_pkg::S_DONE;
        end
      end
      bca_pkg::S_DIV: begin
        if ((range_step && take) || step_last) begin
          state_d = bca_pkg::S_DONE;
        end
      end
      bca_pkg::S_MUL: begin
        if (step_last) begin
          state_d = bca_pkg::S_DONE;
        end
      end
      bca_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bca_pkg::S_IDLE;
        end
      end
      default: state_d = bca_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (ALU operands, ready)
  // --------------------------------------------------------------------------
  always_comb begin
    alu_req    = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bca_pkg::S_IDLE: in_ready_o = 1'b1;
      bca_pkg::S_CHECK: begin
        alu_req.sub = 1'b1;
        if (func_q == bca_pkg::FUNC_ALLOC) begin
          alu_req.a = bca_pkg::ALU_W'(cs_q);   // size ok when cs >= req
          alu_req.b = bca_pkg::ALU_W'(req_q);
        end else begin
          alu_req.a = bca_pkg::ALU_W'(req_q);  // refused when req >= cs
          alu_req.b = bca_pkg::ALU_W'(cs_q);
        end
      end
      bca_pkg::S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = bca_pkg::ALU_W'(rem_q);
        alu_req.b   = bca_pkg::ALU_W'(dvs_q);
      end
      bca_pkg::S_MUL: begin
        alu_req.a = bca_pkg::ALU_W'({acc_q, 1'b0});
        alu_req.b = quo_q[bca_pkg::IDX_W-1] ? bca_pkg::ALU_W'(cs_q) : '0;
      end
      default: begin
        alu_req    = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bca_pkg::S_IDLE;
      cs_q        <= bca_pkg::CHUNK_SIZE_RESET;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_write && paddr[2] == bca_pkg::REG_IDX_CHUNK_SIZE) begin
        cs_q <= pwdata[bca_pkg::CS_W-1:0];
      end
      if (state_q == bca_pkg::S_DONE && out_free) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_q    <= bca_pkg::func_e'(func_i);
          req_q     <= request_size_i;
          off_q     <= offset_i;
          rem_q     <= offset_i;
          dvs_q     <= {cs_q, {bca_pkg::IDX_W{1'b0}}};
          quo_q     <= '0;
          step_q    <= bca_pkg::STEP_W'(bca_pkg::IDX_W);
          acc_q     <= '0;
          idx_q     <= '0;
          stat_q    <= bca_pkg::STAT_OK;
          res_off_q <= '0;
        end
      end
      bca_pkg::S_CHECK: begin
        if (func_q == bca_pkg::FUNC_ALLOC) begin
          if (!take) begin
            stat_q <= bca_pkg::STAT_TOO_LARGE;
          end else if (page_is_full) begin
            stat_q <= bca_pkg::STAT_FULL;
          end else begin
            idx_q  <= low_idx;
            quo_q  <= low_idx;
            step_q <= bca_pkg::STEP_W'(bca_pkg::IDX_W - 1);
          end
        end else if (take) begin
          stat_q <= bca_pkg::STAT_TOO_LARGE;
        end else begin
          res_off_q <= off_q;
        end
      end
      bca_pkg::S_DIV: begin
        dvs_q  <= dvs_q >> 1;
        step_q <= step_q - 1'b1;
        if (range_step) begin
          // offset at or past chunk_size << IDX_W: no chunk in range
          if (take) begin
            stat_q <= bca_pkg::STAT_OUTSIDE;
          end
        end else begin
          if (take) begin
            rem_q <= alu_rsp.sum[bca_pkg::OFF_W-1:0];
          end
          quo_q <= q_new;
          if (step_last) begin
            if (int'(q_new) >= bca_pkg::CHUNK_COUNT) begin
              stat_q <= bca_pkg::STAT_OUTSIDE;
            end else begin
              idx_q <= q_new;
            end
          end
        end
      end
      bca_pkg::S_MUL: begin
        acc_q  <= alu_rsp.sum[bca_pkg::OFF_W-1:0];
        quo_q  <= quo_q << 1;
        step_q <= step_q - 1'b1;
        if (step_last) begin
          res_off_q <= alu_rsp.sum[bca_pkg::OFF_W-1:0];
        end
      end
      bca_pkg::S_DONE: begin
        if (out_free) begin
          out_status_q <= stat_q;
          out_offset_q <= res_off_q;
          out_index_q  <= idx_q;
          out_full_q   <= &used_d;
          out_map_q    <= bca_pkg::MAP_W'(used_d);
        end
      end
      default: begin
        stat_q <= stat_q;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign result_offset_o = out_offset_q;
  assign chunk_index_o   = out_index_q;
  assign page_full_o     = out_full_q;
  assign usage_map_o     = out_map_q;

endmodule

@@ rtl/bca_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_alu: shared add/subtract unit
// One 32-bit adder used for size compares, division steps and shift-add
// multiply steps under control of the allocator sequencer.
// ----------------------------------------------------------------------------
module bca_alu (
  input  bca_pkg::alu_req_t req_i,
  output bca_pkg::alu_rsp_t rsp_o
);

  logic [bca_pkg::ALU_W:0]   total;
  logic [bca_pkg::ALU_W-1:0] b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_op} + (bca_pkg::ALU_W + 1)'(req_i.sub);

  assign rsp_o.sum   = total[bca_pkg::ALU_W-1:0];
  assign rsp_o.carry = total[bca_pkg::ALU_W];

endmodule

@@ rtl/bca_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_checker: port-level checks for the bitmap chunk allocator
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bca_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [bca_pkg::APB_AW-1:0]   paddr,
  input logic [bca_pkg::APB_DW-1:0]   pwdata,
  input logic [bca_pkg::APB_DW-1:0]   prdata,
  input logic                         pready,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   func_i,
  input logic [bca_pkg::REQ_W-1:0]    request_size_i,
  input logic [bca_pkg::OFF_W-1:0]    offset_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   status_o,
  input logic [bca_pkg::OFF_W-1:0]    result_offset_o,
  input logic [bca_pkg::IDX_W-1:0]    chunk_index_o,
  input logic                         page_full_o,
  input logic [bca_pkg::MAP_W-1:0]    usage_map_o
);

  // a request is worked on before the next is taken: ready drops after an accept
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted in back-to-back cycles");

  // full flag must agree with the reported bitmap
  a_full_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (page_full_o == (&usage_map_o[bca_pkg::CHUNK_COUNT-1:0])))
    else $error("page_full disagrees with usage_map");

  // failures report neither an offset nor a chunk
  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bca_pkg::STAT_OK) |->
      (result_offset_o == '0 && chunk_index_o == '0))
    else $error("failed request reports offset or index");

  // a page-full refusal only happens on a full page
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bca_pkg::STAT_FULL) |-> page_full_o)
    else $error("page full status on a page with free chunks");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(usage_map_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_chunk_allocator bca_checker u_bca_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bitmap_chunk_allocator
// A directed table (extremes, every request kind, full page, unaligned and
// out-of-page frees, zero and maximum chunk size) is followed by random
// requests over several chunk sizes. Every accepted request is run through
// a bit-accurate allocator predictor and each result is compared field by
// field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import bca_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          IDLE_SETTLE  = 12;
  localparam int          END_SETTLE   = 20;
  localparam int          PHASE_ITEMS  = 190;
  localparam int          NUM_PHASES   = 8;
  localparam int          NUM_ROWS     = 30;
  localparam logic [63:0] ALL_USED     = {MAP_W{1'b1}};

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] offset;
    logic [IDX_W-1:0] index;
    logic             full;
    logic [MAP_W-1:0] map;
  } alloc_result_t;

  typedef struct packed {
    logic             set_cs;
    logic [CS_W-1:0]  cs;
    func_e            fn;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;
    logic [7:0]       reps;
    logic             typed;
    alloc_result_t    res;
  } directed_row_t;

  localparam alloc_result_t NO_RES = '0;

  // typed rows assume chunk size 1 straight out of reset
  localparam directed_row_t DIRECTED [NUM_ROWS] = '{
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd0, 22'd0, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd0, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1, 22'd0, 8'd1, 1'b1,
      '{STAT_OK, 22'd1, 6'd1, 1'b0, 64'h3}},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'hFFFF_FFFF, 22'd0, 8'd1, 1'b1,
      '{STAT_TOO_LARGE, 22'd0, 6'd0, 1'b0, 64'h3}},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd1, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd1, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_FREE,   32'hFFFF_FFFF, 22'd1, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd1, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'h3F_FFFF, 8'd1, 1'b1,
      '{STAT_OUTSIDE, 22'd0, 6'd0, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd64, 8'd1, 1'b1,
      '{STAT_OUTSIDE, 22'd0, 6'd0, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd63, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd63, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_RESIZE, 32'd0, 22'h3F_FFFF, 8'd1, 1'b1,
      '{STAT_OK, 22'h3F_FFFF, 6'd0, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_RESIZE, 32'd1, 22'd5, 8'd1, 1'b1,
      '{STAT_TOO_LARGE, 22'd0, 6'd0, 1'b0, 64'h1}},
    '{1'b0, 16'd0, FUNC_NOP,    32'hFFFF_FFFF, 22'h3F_FFFF, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd0, 1'b0, 64'h1}},
    // fill the rest of the page
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1, 22'd0, 8'd63, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd0, 22'd0, 8'd1, 1'b1,
      '{STAT_FULL, 22'd0, 6'd0, 1'b1, ALL_USED}},
    // size is checked before fullness
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd2, 22'd0, 8'd1, 1'b1,
      '{STAT_TOO_LARGE, 22'd0, 6'd0, 1'b1, ALL_USED}},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd40, 8'd1, 1'b1,
      '{STAT_OK, 22'd0, 6'd40, 1'b0, 64'hFFFF_FEFF_FFFF_FFFF}},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1, 22'd0, 8'd1, 1'b1,
      '{STAT_OK, 22'd40, 6'd40, 1'b1, ALL_USED}},
    // unaligned free rounds down to the owning chunk
    '{1'b1, 16'd1000, FUNC_FREE, 32'd0, 22'd40999, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1000, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1001, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_RESIZE, 32'd999, 22'd12345, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_RESIZE, 32'd1000, 22'd12345, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd5000, 8'd1, 1'b0, NO_RES},
    // zero chunk size: page has no bytes
    '{1'b1, 16'd0, FUNC_FREE,   32'd0, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd0, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'd1, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_RESIZE, 32'd0, 22'd7, 8'd1, 1'b0, NO_RES},
    '{1'b1, 16'hFFFF, FUNC_FREE, 32'd0, 22'd4128705, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_ALLOC,  32'hFFFF, 22'd0, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'h3F_FFFF, 8'd1, 1'b0, NO_RES},
    '{1'b0, 16'd0, FUNC_FREE,   32'd0, 22'd4194239, 8'd1, 1'b0, NO_RES}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready_o;
  func_e              func_q;
  logic [REQ_W-1:0]   size_q;
  logic [OFF_W-1:0]   off_q;
  logic               out_valid_o;
  logic               out_ready;
  logic [1:0]         status_o;
  logic [OFF_W-1:0]   result_offset_o;
  logic [IDX_W-1:0]   chunk_index_o;
  logic               page_full_o;
  logic [MAP_W-1:0]   usage_map_o;

  // typed expectation travels with the request payload
  logic               exp_typed;
  alloc_result_t      exp_typed_res;

  logic [MAP_W-1:0]   page_map;
  logic [CS_W-1:0]    chunk_bytes;
  alloc_result_t      expected_results [$];
  int unsigned        err_cnt;
  int unsigned        idle_cycles;

  bitmap_chunk_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .func_i          (func_q),
    .request_size_i  (size_q),
    .offset_i        (off_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .chunk_index_o   (chunk_index_o),
    .page_full_o     (page_full_o),
    .usage_map_o     (usage_map_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic alloc_result_t predict_request(input func_e fn,
                                                    input logic [REQ_W-1:0] sz,
                                                    input logic [OFF_W-1:0] off);
    alloc_result_t r;
    logic [31:0]   quot;
    bit            found;
    r = '0;
    r.status = STAT_OK;
    found = 1'b0;
    case (fn)
      FUNC_ALLOC: begin
        if (sz > REQ_W'(chunk_bytes)) begin
          r.status = STAT_TOO_LARGE;
        end else if (&page_map) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = 0; i < CHUNK_COUNT; i++) begin
            if (!found && !page_map[i]) begin
              found = 1'b1;
              page_map[i] = 1'b1;
              r.index = IDX_W'(i);
              r.offset = OFF_W'(32'(chunk_bytes) * 32'(i));
            end
          end
        end
      end
      FUNC_FREE: begin
        if (chunk_bytes == '0) begin
          r.status = STAT_OUTSIDE;
        end else begin
          quot = 32'(off) / 32'(chunk_bytes);
          if (quot >= CHUNK_COUNT) begin
            r.status = STAT_OUTSIDE;
          end else begin
            page_map[quot[IDX_W-1:0]] = 1'b0;
            r.index = quot[IDX_W-1:0];
          end
        end
      end
      FUNC_RESIZE: begin
        if (sz < REQ_W'(chunk_bytes)) r.offset = off;
        else r.status = STAT_TOO_LARGE;
      end
      default: ;
    endcase
    r.full = &page_map;
    r.map = page_map;
    return r;
  endfunction

  // request/result tracking and watchdog
  always @(posedge clk_i) begin : monitor
    alloc_result_t exp_r;
    bit            activity;
    activity = psel;
    if (rst_ni && out_valid_o && out_ready) begin
      activity = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          err_cnt++;
        end
        if (result_offset_o !== exp_r.offset) begin
          $error("result_offset: expected %0d, got %0d", exp_r.offset, result_offset_o);
          err_cnt++;
        end
        if (chunk_index_o !== exp_r.index) begin
          $error("chunk_index: expected %0d, got %0d", exp_r.index, chunk_index_o);
          err_cnt++;
        end
        if (page_full_o !== exp_r.full) begin
          $error("page_full: expected %0d, got %0d", exp_r.full, page_full_o);
          err_cnt++;
        end
        if (usage_map_o !== exp_r.map) begin
          $error("usage_map: expected %h, got %h", exp_r.map, usage_map_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_valid && in_ready_o) begin
      activity = 1'b1;
      exp_r = predict_request(func_q, size_q, off_q);
      expected_results.push_back(exp_typed ? exp_typed_res : exp_r);
    end
    if (activity || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, a few long, some clean runs
  initial begin : result_sink
    int unsigned pick;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (pick < 50) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end else if (pick < 85) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else if (pick < 96) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(4, 12)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(input func_e fn, input logic [REQ_W-1:0] sz,
                              input logic [OFF_W-1:0] off, input logic typed,
                              input alloc_result_t res);
    in_valid      <= 1'b1;
    func_q        <= fn;
    size_q        <= sz;
    off_q         <= off;
    exp_typed     <= typed;
    exp_typed_res <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // only with nothing in flight; the block is idle once the last result left
  task automatic write_chunk_size(input logic [CS_W-1:0] value);
    drain_results();
    repeat (IDLE_SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_CHUNK_SIZE, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    chunk_bytes = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CS_W-1:0] !== value) begin
      $error("chunk_size readback: expected %0d, got %0d", value, prdata[CS_W-1:0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic issue_random_request();
    int unsigned      pick;
    int unsigned      sel;
    int unsigned      cs;
    logic [31:0]      pos;
    logic [REQ_W-1:0] sz;
    logic [OFF_W-1:0] off;
    func_e            fn;
    cs   = chunk_bytes;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    sz   = $urandom;
    off  = OFF_W'($urandom);
    if (pick < 40) begin
      fn = FUNC_ALLOC;
      if (sel < 7) sz = $urandom_range(0, cs);
      else if (sel == 7) sz = cs;
      else if (sel == 8) sz = cs + 1;
    end else if (pick < 75) begin
      fn = FUNC_FREE;
      if (sel < 7 && cs != 0) begin
        pos = $urandom_range(0, 63) * cs + $urandom_range(0, cs - 1);
        off = OFF_W'(pos);
      end else if (sel == 9) begin
        // just past the end of the page
        pos = 64 * cs + $urandom_range(0, cs);
        off = (pos > 32'h3F_FFFF) ? 22'h3F_FFFF : OFF_W'(pos);
      end
    end else if (pick < 95) begin
      fn = FUNC_RESIZE;
      if (sel < 4) sz = $urandom_range(0, cs);
      else if (sel < 6) sz = cs;
      else if (sel < 8 && cs != 0) sz = cs - 1;
    end else begin
      fn = FUNC_NOP;
    end
    send_request(fn, sz, off, 1'b0, NO_RES);
  endtask

  initial begin : stimulus
    directed_row_t row;
    int unsigned   sent;
    int unsigned   phase_cs [NUM_PHASES];
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    func_q        <= FUNC_ALLOC;
    size_q        <= '0;
    off_q         <= '0;
    exp_typed     <= 1'b0;
    exp_typed_res <= NO_RES;
    page_map      = '0;
    chunk_bytes   = CHUNK_SIZE_RESET;
    err_cnt       = 0;
    idle_cycles   = 0;
    phase_cs = '{65535, 2, 1, 17, 0, 1000, $urandom_range(3, 65534),
                 $urandom_range(3, 65534)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.set_cs) write_chunk_size(row.cs);
      for (int k = 0; k < row.reps; k++) begin
        send_request(row.fn, row.size, row.off, row.typed, row.res);
        pause_sender(pick_gap());
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_chunk_size(CS_W'(phase_cs[p]));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 3) begin
          // back-to-back allocations run the page full
          repeat ($urandom_range(64, 70)) begin
            send_request(FUNC_ALLOC, $urandom_range(0, chunk_bytes), '0, 1'b0, NO_RES);
            sent++;
          end
        end else begin
          issue_random_request();
          sent++;
        end
        if ($urandom_range(0, 99) < 2) drain_results();
        else pause_sender(pick_gap());
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bca_pkg.sv
rtl/bca_alu.sv
rtl/bitmap_chunk_allocator.sv
rtl/bca_checker.sv
test/testbench.sv
